### sv/refcounted_page_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the reference-counted page allocator.
// Each macro checks one implication at the rising edge of clock, and the
// check is disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rpa_pkg.sv
// ---------------------------------------------------------------------------
// rpa_pkg
// Types, codes and helper functions for the reference-counted page allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpa_pkg;

   localparam int NUM_PAGES   = 32768;
   localparam int PAGE_BITS   = 15;
   localparam int DEPTH_BITS  = 16;
   localparam int COUNT_BITS  = 8;
   localparam int OFFSET_BITS = 12;
   localparam int MODE_BITS   = 3;
   localparam int STATUS_BITS = 2;
   localparam int REQ_BITS    = 32;
   localparam int RSP_BITS    = 32;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ALLOC = 3'd0,
      MODE_FREE  = 3'd1,
      MODE_INC   = 3'd2,
      MODE_DEC   = 3'd3,
      MODE_READ  = 3'd4
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_OOM       = 2'd1,
      ST_BAD_ADDR  = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      CSR_LOWEST = 1'b0,
      CSR_TOP    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   function automatic logic [DEPTH_BITS-1:0] clamp_top(input logic [DEPTH_BITS-1:0] top);
      return (top > DEPTH_BITS'(NUM_PAGES)) ? DEPTH_BITS'(NUM_PAGES) : top;
   endfunction

   function automatic logic [DEPTH_BITS-1:0] pool_span(input logic [PAGE_BITS-1:0] lowest,
                                                       input logic [DEPTH_BITS-1:0] top);
      logic [DEPTH_BITS-1:0] top_c;
      logic [DEPTH_BITS-1:0] low_w;
      top_c = clamp_top(top);
      low_w = DEPTH_BITS'(lowest);
      return (top_c > low_w) ? (top_c - low_w) : '0;
   endfunction

endpackage

### sv/refcounted_page_allocator.sv
// ---------------------------------------------------------------------------
// refcounted_page_allocator
// Page-frame allocator with a LIFO free stack and per-page reference counts.
// ---------------------------------------------------------------------------
// Requests enter on the req_ stream: tuser carries the mode (alloc, free,
// increment, decrement, read count) and tdata the page index and offset.
// Every request yields exactly one item on the rsp_ stream with the page,
// a status code, the count after the operation and a pushed flag.
// The csr_ channel writes the lowest and top page registers; a write
// re-seeds the free stack to the new span and keeps the count table.
// An accepted request reads the count memory and the stack memory at the
// accepting edge and commits at the next edge, or once the output register
// is free, and the block takes no new request until the last one has
// committed. The single read-modify-write of the count memory sets that
// limit. After reset the block clears all 32768 count entries, one entry
// per cycle, with req_tready low; csr writes are taken meanwhile.
// When the receiver stalls, the result is held in the output register and
// the next request waits in its commit cycle until that item is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module refcounted_page_allocator
   import rpa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // page_index [14:0], page_offset [26:15], zero fill above
   input  logic [REQ_BITS-1:0]      req_tdata,
   // mode [2:0]
   input  logic [MODE_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // result_page [14:0], status [16:15], ref_count [24:17],
   // returned_to_pool [25], zero fill above
   output logic [RSP_BITS-1:0]      rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   state_type                state_ff, state_in;
   logic [PAGE_BITS-1:0]     clr_addr_ff, clr_addr_in;
   logic [PAGE_BITS-1:0]     lowest_ff, lowest_in;
   logic [DEPTH_BITS-1:0]    top_ff, top_in;
   logic [DEPTH_BITS-1:0]    depth_ff, depth_in;
   logic [DEPTH_BITS-1:0]    lwm_ff, lwm_in;
   logic [MODE_BITS-1:0]     mode_ff;
   logic [PAGE_BITS-1:0]     page_ff;
   logic [OFFSET_BITS-1:0]   offset_ff;
   logic [COUNT_BITS-1:0]    cnt_rd_ff;
   logic [PAGE_BITS-1:0]     stk_rd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]      rsp_data_ff;

   logic [COUNT_BITS-1:0]    count_mem [NUM_PAGES];
   logic [PAGE_BITS-1:0]     stack_mem [NUM_PAGES];

   logic                     req_accept;
   logic                     csr_write;
   logic                     commit;
   logic [PAGE_BITS-1:0]     req_page;
   logic [PAGE_BITS-1:0]     stk_raddr;
   logic [DEPTH_BITS-1:0]    top_c;
   logic [DEPTH_BITS-1:0]    new_depth;
   logic [DEPTH_BITS-1:0]    new_span;

   logic [PAGE_BITS-1:0]     x_page;
   status_type               x_status;
   logic [COUNT_BITS-1:0]    x_count;
   logic                     x_pushed;
   logic                     x_cnt_we;
   logic [PAGE_BITS-1:0]     x_cnt_addr;
   logic [COUNT_BITS-1:0]    x_cnt_data;
   logic                     x_stk_we;
   logic [DEPTH_BITS-1:0]    x_depth;
   logic [DEPTH_BITS-1:0]    x_lwm;
   logic                     free_bad;

   logic                     cnt_we;
   logic [PAGE_BITS-1:0]     cnt_waddr;
   logic [COUNT_BITS-1:0]    cnt_wdata;

   assign req_page   = req_tdata[PAGE_BITS-1:0];
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_valid && csr_ready;
   assign commit     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign stk_raddr  = PAGE_BITS'(depth_ff - 1'b1);
   assign top_c      = clamp_top(top_ff);
   assign new_depth  = depth_ff - 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      csr_ready  = 1'b1;
      case (state_ff)
         S_CLEAR: req_tready = 1'b0;
         S_IDLE:  req_tready = 1'b1;
         S_EXEC:  req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   // Operation on the values read from both memories.
   always_comb begin
      x_page     = page_ff;
      x_status   = ST_OK;
      x_count    = '0;
      x_pushed   = 1'b0;
      x_cnt_we   = 1'b0;
      x_cnt_addr = page_ff;
      x_cnt_data = '0;
      x_stk_we   = 1'b0;
      x_depth    = depth_ff;
      x_lwm      = lwm_ff;
      free_bad   = (offset_ff != '0) || (page_ff < lowest_ff)
                   || (DEPTH_BITS'(page_ff) >= top_c);
      case (mode_ff)
         MODE_ALLOC: begin
            if (depth_ff == '0) begin
               x_page   = '0;
               x_status = ST_OOM;
            end else begin
               x_depth = new_depth;
               if (new_depth < lwm_ff) begin
                  x_page = PAGE_BITS'(DEPTH_BITS'(lowest_ff) + new_depth);
                  x_lwm  = new_depth;
               end else begin
                  x_page = stk_rd_ff;
               end
               x_cnt_addr = x_page;
               x_cnt_data = COUNT_BITS'(1);
               x_cnt_we   = 1'b1;
               x_count    = COUNT_BITS'(1);
            end
         end
         MODE_FREE: begin
            if (free_bad) begin
               x_status = ST_BAD_ADDR;
            end else if (cnt_rd_ff == '0) begin
               x_status = ST_NOT_ALLOC;
            end else begin
               x_count    = cnt_rd_ff - 1'b1;
               x_cnt_data = x_count;
               x_cnt_we   = 1'b1;
               if ((x_count == '0) && (depth_ff < DEPTH_BITS'(NUM_PAGES))) begin
                  x_stk_we = 1'b1;
                  x_depth  = depth_ff + 1'b1;
                  x_pushed = 1'b1;
               end
            end
         end
         MODE_INC: begin
            x_count    = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
            x_cnt_data = x_count;
            x_cnt_we   = 1'b1;
         end
         MODE_DEC: begin
            if (cnt_rd_ff == '0) begin
               x_status = ST_NOT_ALLOC;
            end else begin
               x_count    = cnt_rd_ff - 1'b1;
               x_cnt_data = x_count;
               x_cnt_we   = 1'b1;
            end
         end
         MODE_READ: begin
            x_count = cnt_rd_ff;
         end
         default: begin
            x_status = ST_BAD_ADDR;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else begin
         cnt_we    = commit && x_cnt_we;
         cnt_waddr = x_cnt_addr;
         cnt_wdata = x_cnt_data;
      end
   end

   always_comb begin
      lowest_in = lowest_ff;
      top_in    = top_ff;
      if (csr_write && (csr_index == CSR_LOWEST)) begin
         lowest_in = csr_data[PAGE_BITS-1:0];
      end
      if (csr_write && (csr_index == CSR_TOP)) begin
         top_in = csr_data;
      end
      new_span = pool_span(lowest_in, top_in);
      if (csr_write) begin
         depth_in = new_span;
         lwm_in   = new_span;
      end else if (commit) begin
         depth_in = x_depth;
         lwm_in   = x_lwm;
      end else begin
         depth_in = depth_ff;
         lwm_in   = lwm_ff;
      end
      clr_addr_in = (state_ff == S_CLEAR) ? clr_addr_ff + 1'b1 : clr_addr_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         lowest_ff    <= '0;
         top_ff       <= DEPTH_BITS'(NUM_PAGES);
         depth_ff     <= DEPTH_BITS'(NUM_PAGES);
         lwm_ff       <= DEPTH_BITS'(NUM_PAGES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         lowest_ff    <= lowest_in;
         top_ff       <= top_in;
         depth_ff     <= depth_in;
         lwm_ff       <= lwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff   <= req_tuser;
         page_ff   <= req_page;
         offset_ff <= req_tdata[PAGE_BITS +: OFFSET_BITS];
      end
      if (commit) begin
         rsp_data_ff <= RSP_BITS'({x_pushed, x_count, x_status, x_page});
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (req_accept) begin
         cnt_rd_ff <= count_mem[req_page];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && x_stk_we) begin
         stack_mem[PAGE_BITS'(depth_ff)] <= page_ff;
      end
      if (req_accept) begin
         stk_rd_ff <= stack_mem[stk_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "refcounted_page_allocator_assert.svh"

   `RPA_ASSERT_SAME(a_depth_range, 1'b1, depth_ff <= DEPTH_BITS'(NUM_PAGES), "stack depth overflow")
   `RPA_ASSERT_SAME(a_lwm_below_depth, 1'b1, lwm_ff <= depth_ff, "low-water mark above depth")
   `RPA_ASSERT_NEXT(a_rsp_from_commit, !rsp_valid_ff && !commit, !rsp_tvalid, "item without commit")

endmodule

### tb/refcounted_page_allocator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page allocator regression
// Drives alloc, free, count and unused-mode requests into the reference-
// counted page allocator across several pool settings and idling profiles.
// A scoreboard keeps its own free stack and count table, predicts every
// response at the time a request is accepted, and compares each response
// field by field, in order.
// ---------------------------------------------------------------------------

module refcounted_page_allocator_test;
   import rpa_pkg::*;

   typedef struct {
      logic [PAGE_BITS-1:0]  page;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
      logic                  pushed;
   } pool_reply_type;

   class page_pool_tracker_type;
      logic [COUNT_BITS-1:0] page_counts [NUM_PAGES];
      logic [PAGE_BITS-1:0]  stacked_pages [NUM_PAGES];
      int unsigned           depth;
      int unsigned           water_mark;
      int unsigned           lowest;
      int unsigned           top;
      pool_reply_type        pending_rsp [$];
      logic [PAGE_BITS-1:0]  held_pages [$];
      int                    mismatches;
      int                    requests_seen;
      int                    results_seen;
      int                    status_seen [4];

      function new();
         foreach (page_counts[i]) begin
            page_counts[i] = '0;
            stacked_pages[i] = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches = 0;
         requests_seen = 0;
         results_seen = 0;
         lowest = 0;
         top = NUM_PAGES;
         reseed();
      endfunction

      function int unsigned clipped_top();
         return (top > NUM_PAGES) ? NUM_PAGES : top;
      endfunction

      function void reseed();
         depth = (clipped_top() > lowest) ? clipped_top() - lowest : 0;
         water_mark = depth;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == CSR_LOWEST) begin
            lowest = 32'(value[PAGE_BITS-1:0]);
         end else begin
            top = 32'(value);
         end
         reseed();
      endfunction

      function logic [PAGE_BITS-1:0] pick_held();
         int                   idx;
         logic [PAGE_BITS-1:0] p;
         if (held_pages.size() == 0) return PAGE_BITS'($urandom);
         idx = $urandom_range(0, held_pages.size() - 1);
         p = held_pages[idx];
         if (page_counts[p] == '0) held_pages.delete(idx);
         return p;
      endfunction

      function void note_request(logic [MODE_BITS-1:0] mode, logic [PAGE_BITS-1:0] page,
                                 logic [OFFSET_BITS-1:0] offset);
         pool_reply_type       r;
         logic [PAGE_BITS-1:0] p;
         r.page = page;
         r.status = ST_OK;
         r.count = '0;
         r.pushed = 1'b0;
         requests_seen++;
         case (mode)
            MODE_ALLOC: begin
               if (depth == 0) begin
                  r.page = '0;
                  r.status = ST_OOM;
               end else begin
                  depth--;
                  if (depth < water_mark) begin
                     p = PAGE_BITS'(lowest + depth);
                     water_mark = depth;
                  end else begin
                     p = stacked_pages[PAGE_BITS'(depth)];
                  end
                  page_counts[p] = COUNT_BITS'(1);
                  r.page = p;
                  r.count = COUNT_BITS'(1);
                  held_pages.push_back(p);
               end
            end
            MODE_FREE: begin
               if (offset != '0 || page < lowest || page >= clipped_top()) begin
                  r.status = ST_BAD_ADDR;
               end else if (page_counts[page] == '0) begin
                  r.status = ST_NOT_ALLOC;
               end else begin
                  page_counts[page] = page_counts[page] - 1'b1;
                  r.count = page_counts[page];
                  if (page_counts[page] == '0 && depth < NUM_PAGES) begin
                     stacked_pages[PAGE_BITS'(depth)] = page;
                     depth++;
                     r.pushed = 1'b1;
                  end
               end
            end
            MODE_INC: begin
               if (page_counts[page] != COUNT_MAX) begin
                  page_counts[page] = page_counts[page] + 1'b1;
               end
               r.count = page_counts[page];
            end
            MODE_DEC: begin
               if (page_counts[page] == '0) begin
                  r.status = ST_NOT_ALLOC;
               end else begin
                  page_counts[page] = page_counts[page] - 1'b1;
                  r.count = page_counts[page];
               end
            end
            MODE_READ: begin
               r.count = page_counts[page];
            end
            default: begin
               r.status = ST_BAD_ADDR;
            end
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(logic [RSP_BITS-1:0] data);
         pool_reply_type        want;
         logic [PAGE_BITS-1:0]  got_page;
         logic [1:0]            got_status;
         logic [COUNT_BITS-1:0] got_count;
         logic                  got_pushed;
         got_page = data[14:0];
         got_status = data[16:15];
         got_count = data[24:17];
         got_pushed = data[25];
         results_seen++;
         status_seen[got_status]++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result %0d: page %0d status %0d count %0d pushed %0d",
                        results_seen, got_page, got_status, got_count, got_pushed);
            return;
         end
         want = pending_rsp.pop_front();
         if (got_page !== want.page || got_status !== want.status ||
             got_count !== want.count || got_pushed !== want.pushed) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch on result %0d: expected page %0d status %0d count %0d ",
                         "pushed %0d, got page %0d status %0d count %0d pushed %0d"},
                        results_seen, want.page, want.status, want.count, want.pushed,
                        got_page, got_status, got_count, got_pushed);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata = '0;
   logic [MODE_BITS-1:0]     req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index = CSR_LOWEST;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   page_pool_tracker_type tracker;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    csr_writes = 0;

   refcounted_page_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   task automatic send_request(input logic [MODE_BITS-1:0] mode,
                               input logic [PAGE_BITS-1:0] page,
                               input logic [OFFSET_BITS-1:0] offset);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= REQ_BITS'({offset, page});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(mode, page, offset);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, value);
      csr_writes++;
   endtask

   task automatic configure(input logic [PAGE_BITS-1:0] lowest,
                            input logic [CSR_DATA_BITS-1:0] top);
      write_csr(CSR_LOWEST, CSR_DATA_BITS'(lowest));
      write_csr(CSR_TOP, top);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_request();
      int                     sel;
      int unsigned            span;
      logic [MODE_BITS-1:0]   mode;
      logic [PAGE_BITS-1:0]   page;
      logic [OFFSET_BITS-1:0] offset;
      sel = $urandom_range(0, 99);
      page = PAGE_BITS'($urandom);
      offset = OFFSET_BITS'($urandom);
      if (sel < 30) begin
         mode = MODE_ALLOC;
      end else if (sel < 55) begin
         mode = MODE_FREE;
         page = tracker.pick_held();
         offset = '0;
      end else if (sel < 85) begin
         mode = (sel < 67) ? MODE_INC : (sel < 77) ? MODE_DEC : MODE_READ;
         page = tracker.pick_held();
      end else if (sel < 92) begin
         mode = MODE_FREE;
         span = (tracker.clipped_top() > tracker.lowest) ?
                tracker.clipped_top() - tracker.lowest : 0;
         page = PAGE_BITS'(tracker.lowest + $urandom_range(0, span + 1) - 1);
         if ($urandom_range(0, 3) != 0) offset = '0;
      end else if (sel < 97) begin
         mode = MODE_BITS'(MODE_INC) + MODE_BITS'($urandom_range(0, 2));
      end else begin
         mode = MODE_BITS'(MODE_READ) + MODE_BITS'($urandom_range(1, 3));
      end
      send_request(mode, page, offset);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int                   lo;
      int                   guard;
      logic [PAGE_BITS-1:0] hot_page;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      configure('0, 16'(NUM_PAGES));

      // The pool starts full, so freeing a page counted up by hand cannot push it.
      send_request(MODE_INC, PAGE_BITS'(5), '0);
      send_request(MODE_FREE, PAGE_BITS'(5), '0);
      send_request(MODE_FREE, PAGE_BITS'(5), '0);
      send_request(MODE_DEC, PAGE_BITS'(5), '0);
      send_request(MODE_ALLOC, '1, '1);
      send_request(MODE_FREE, '1, '1);
      send_request(MODE_FREE, '1, '0);
      send_request(MODE_ALLOC, '0, '0);
      send_request(MODE_READ, '1, '1);
      send_request(MODE_DEC, '1, '0);
      send_request(MODE_FREE, '1, '0);
      send_request(MODE_READ, '0, '0);
      for (int m = MODE_READ + 1; m < (1 << MODE_BITS); m++)
         send_request(MODE_BITS'(m), '1, '1);
      wait_idle();
      configure(PAGE_BITS'(100), CSR_DATA_BITS'(104));
      repeat (5) send_request(MODE_ALLOC, PAGE_BITS'($urandom), OFFSET_BITS'($urandom));
      send_request(MODE_FREE, PAGE_BITS'(99), '0);
      send_request(MODE_FREE, PAGE_BITS'(104), '0);
      send_request(MODE_FREE, PAGE_BITS'(101), '0);
      send_request(MODE_ALLOC, '0, '0);
      wait_idle();
      configure(PAGE_BITS'(20000), CSR_DATA_BITS'(20));
      send_request(MODE_ALLOC, '0, '0);
      send_request(MODE_FREE, PAGE_BITS'(20000), '0);

      // Drive one page's count into saturation and back down by one.
      wait_idle();
      configure('0, 16'(NUM_PAGES));
      send_request(MODE_ALLOC, '0, '0);
      hot_page = tracker.held_pages[$];
      repeat (256) send_request(MODE_INC, hot_page, OFFSET_BITS'($urandom));
      send_request(MODE_READ, hot_page, '0);
      send_request(MODE_DEC, hot_page, '0);

      for (int seg = 0; seg < 8; seg++) begin
         wait_idle();
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
            default: begin send_idle_pct = 38; recv_idle_pct = 38; end
         endcase
         case (seg)
            0: configure('0, '1);
            1: configure('1, 16'(NUM_PAGES));
            2: configure(PAGE_BITS'(20000), CSR_DATA_BITS'(20));
            3: begin
               lo = $urandom_range(0, 32700);
               configure(PAGE_BITS'(lo), CSR_DATA_BITS'(lo + $urandom_range(1, 48)));
            end
            4: configure('0, CSR_DATA_BITS'(1));
            5: configure(PAGE_BITS'($urandom), CSR_DATA_BITS'($urandom));
            6: begin
               lo = $urandom_range(0, 32760);
               configure(PAGE_BITS'(lo), CSR_DATA_BITS'(lo + $urandom_range(2, 16)));
            end
            default: configure('0, 16'(NUM_PAGES));
         endcase
         repeat (150) random_request();
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (tracker.pending_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (tracker.pending_rsp.size() != 0) begin
         $display("%0d expected results never arrived", tracker.pending_rsp.size());
         tracker.mismatches += tracker.pending_rsp.size();
      end

      $display("Ran %0d requests, %0d results, %0d register writes, four idling mixes.",
               tracker.requests_seen, tracker.results_seen, csr_writes);
      $display("Responses seen: ok %0d, out of memory %0d, bad address %0d, not allocated %0d.",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_OOM],
               tracker.status_seen[ST_BAD_ADDR], tracker.status_seen[ST_NOT_ALLOC]);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
